### rtl/mfsp_pkg.sv
// Shared constants and types for the management frame SSID parser.
package mfsp_pkg;

   // Sizes
   localparam int SSID_BYTES      = 32;
   localparam int MAX_FRAME_BYTES = 4096;
   localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
   localparam int LEN_W           = $clog2(SSID_BYTES + 1);
   localparam int IDX_W           = $clog2(SSID_BYTES);
   localparam int SLOT_W          = 1;
   localparam int ADDR_W          = SLOT_W + IDX_W;
   localparam int RAM_DEPTH       = 2 * SSID_BYTES;
   localparam int BSSID_BYTES     = 6;
   localparam int BSSID_W         = 8 * BSSID_BYTES;
   localparam int RSP_DATA_W      = 2 + BSSID_W + LEN_W + 8;

   // Byte positions inside the frame
   localparam logic [POS_W-1:0] POS_LAST    = POS_W'(MAX_FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] POS_BSSID   = POS_W'(16);
   localparam logic [POS_W-1:0] POS_CAP     = POS_W'(34);
   localparam logic [POS_W-1:0] POS_MIN_END = POS_W'(35);
   localparam logic [POS_W-1:0] POS_ELEM    = POS_W'(36);

   // Field masks and element tags
   localparam logic [7:0] TYPE_MASK    = 8'h0C;
   localparam logic [7:0] PRIVACY_MASK = 8'h10;
   localparam logic [7:0] TAG_SSID     = 8'h00;

   // Element walker phase
   typedef enum logic [1:0] {
      PH_TAG,
      PH_LEN,
      PH_BODY,
      PH_DONE
   } phase_type;

   // Per-frame summary handed from the parser to the result emitter
   typedef struct packed {
      logic               ok;
      logic               secured;
      logic [BSSID_W-1:0] bssid;
      logic [LEN_W-1:0]   keep_len;
      logic [SLOT_W-1:0]  slot;
   } desc_type;

endpackage

### rtl/mfsp_ram.sv
// Generic simple dual-port RAM with a registered, enabled read.
module mfsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mfsp_front.sv
// Byte parser: checks the header, latches BSSID and privacy, walks elements.
module mfsp_front
   import mfsp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   input  logic              in_last,
   input  logic              queue_full,
   output logic              push,
   output desc_type          push_desc,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [7:0]        wr_data
);

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               failed_ff, failed_in;
   logic [BSSID_W-1:0] bssid_ff, bssid_in;
   logic               privacy_ff, privacy_in;
   phase_type          phase_ff, phase_in;
   logic [7:0]         tag_ff, tag_in;
   logic [7:0]         remaining_ff, remaining_in;
   logic               found_ff, found_in;
   logic [LEN_W-1:0]   count_ff, count_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   logic               accept;
   logic               store_byte;
   logic               frame_fail;

   // A new word is taken whenever the descriptor queue has room.
   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   // The SSID byte goes to the RAM while inside an SSID body and below the cap.
   assign store_byte = (pos_ff >= POS_ELEM) && (phase_ff == PH_BODY)
                       && (tag_ff == TAG_SSID) && (count_ff < LEN_W'(SSID_BYTES));

   always_comb begin
      wr_en   = accept && store_byte;
      wr_addr = {slot_ff, count_ff[IDX_W-1:0]};
      wr_data = in_byte;
   end

   // Header fields and element walk for the current byte.
   always_comb begin
      pos_in       = pos_ff;
      failed_in    = failed_ff;
      bssid_in     = bssid_ff;
      privacy_in   = privacy_ff;
      phase_in     = phase_ff;
      tag_in       = tag_ff;
      remaining_in = remaining_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;

      if (accept) begin
         if ((pos_ff == '0) && ((in_byte & TYPE_MASK) != 8'h00)) begin
            failed_in = 1'b1;
         end
         for (int i = 0; i < BSSID_BYTES; i++) begin
            if (pos_ff == POS_BSSID + POS_W'(i)) begin
               bssid_in[8*i +: 8] = in_byte;
            end
         end
         if (pos_ff == POS_CAP) begin
            privacy_in = (in_byte & PRIVACY_MASK) != 8'h00;
         end

         if (pos_ff >= POS_ELEM) begin
            unique case (phase_ff)
               PH_TAG: begin
                  tag_in   = in_byte;
                  phase_in = PH_LEN;
               end
               PH_LEN: begin
                  remaining_in = in_byte;
                  if (tag_ff == TAG_SSID) begin
                     found_in = 1'b1;
                     count_in = '0;
                  end
                  if (in_byte == 8'h00) begin
                     phase_in = (tag_ff == TAG_SSID) ? PH_DONE : PH_TAG;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
               PH_BODY: begin
                  if (store_byte) begin
                     count_in = count_ff + LEN_W'(1);
                  end
                  remaining_in = remaining_ff - 8'd1;
                  if (remaining_ff == 8'd1) begin
                     phase_in = (tag_ff == TAG_SSID) ? PH_DONE : PH_TAG;
                  end
               end
               PH_DONE: begin
                  phase_in = PH_DONE;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end

         if (pos_ff != POS_LAST) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   // Frame verdict after the final byte has been applied.
   assign frame_fail = failed_in || (pos_ff < POS_MIN_END) || (phase_in != PH_DONE)
                       || !found_in;

   always_comb begin
      push               = accept && in_last;
      push_desc.ok       = !frame_fail;
      push_desc.secured  = !frame_fail && privacy_in;
      push_desc.bssid    = frame_fail ? '0 : bssid_in;
      push_desc.keep_len = frame_fail ? '0 : count_in;
      push_desc.slot     = slot_ff;
   end

   // State registers; all frame state restarts after the final byte, and the RAM slot toggles.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         failed_ff    <= 1'b0;
         bssid_ff     <= '0;
         privacy_ff   <= 1'b0;
         phase_ff     <= PH_TAG;
         tag_ff       <= '0;
         remaining_ff <= '0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         slot_ff      <= '0;
      end else if (push) begin
         pos_ff       <= '0;
         failed_ff    <= 1'b0;
         bssid_ff     <= '0;
         privacy_ff   <= 1'b0;
         phase_ff     <= PH_TAG;
         tag_ff       <= '0;
         remaining_ff <= '0;
         found_ff     <= 1'b0;
         count_ff     <= '0;
         slot_ff      <= slot_ff + SLOT_W'(1);
      end else begin
         pos_ff       <= pos_in;
         failed_ff    <= failed_in;
         bssid_ff     <= bssid_in;
         privacy_ff   <= privacy_in;
         phase_ff     <= phase_in;
         tag_ff       <= tag_in;
         remaining_ff <= remaining_in;
         found_ff     <= found_in;
         count_ff     <= count_in;
         slot_ff      <= slot_in;
      end
   end

endmodule

### rtl/mfsp_queue.sv
// Two-entry queue of frame descriptors between the parser and the emitter.
module mfsp_queue
   import mfsp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output desc_type head_desc
);

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_desc  = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

### rtl/mfsp_back.sv
// Result emitter: turns one frame descriptor into its run of result words.
module mfsp_back
   import mfsp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  desc_type          head_desc,
   output logic              pop,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [7:0]        rd_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_ok,
   output logic              out_secured,
   output logic [BSSID_W-1:0] out_bssid,
   output logic [LEN_W-1:0]  out_len,
   output logic [7:0]        out_byte,
   output logic              out_last
);

   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               valid_ff, valid_in;
   logic               ok_ff, secured_ff, use_ram_ff, last_ff;
   logic [BSSID_W-1:0] bssid_ff;
   logic [LEN_W-1:0]   len_ff;

   logic               advance;
   logic               use_ram;
   logic               is_last;

   // A new word is loaded whenever a descriptor waits and the output register is free or drains.
   assign advance = head_valid && (!valid_ff || out_ready);
   assign use_ram = head_desc.keep_len != '0;
   assign is_last = !use_ram || ({1'b0, idx_ff} == head_desc.keep_len - LEN_W'(1));

   always_comb begin
      pop     = advance && is_last;
      rd_en   = advance && use_ram;
      rd_addr = {head_desc.slot, idx_ff};
      idx_in  = idx_ff;
      if (advance) begin
         idx_in = is_last ? '0 : idx_ff + IDX_W'(1);
      end
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload; the SSID byte itself comes from the RAM read register.
   always_ff @(posedge clock) begin
      if (advance) begin
         ok_ff      <= head_desc.ok;
         secured_ff <= head_desc.secured;
         bssid_ff   <= head_desc.bssid;
         len_ff     <= head_desc.keep_len;
         use_ram_ff <= use_ram;
         last_ff    <= is_last;
      end
   end

   assign out_valid   = valid_ff;
   assign out_ok      = ok_ff;
   assign out_secured = secured_ff;
   assign out_bssid   = bssid_ff;
   assign out_len     = len_ff;
   assign out_byte    = use_ram_ff ? rd_data : 8'h00;
   assign out_last    = last_ff;

endmodule

### rtl/mgmt_frame_ssid_parser.sv
// Top level of the management frame SSID parser.
//
// The req channel takes one frame byte per word, from byte zero, with tlast on the final
// byte. For each frame the rsp channel delivers a run of words: one per kept SSID byte (up
// to 32) on success, one word with an empty SSID, or one failure word with every field zero.
// tlast marks the last word of a run. Bytes are taken at one per cycle while the queue has
// room. The parser writes SSID bytes into one half of a 64-entry RAM; the frame summary then
// passes through a two-entry queue, and the emitter reads the other half at one result word
// per cycle while rsp_tready is high. With the emitter idle, a frame's summary is registered
// in the queue entry after its last byte is accepted, then its first result word in the
// emitter output register. Two finished frames may wait for the emitter; while both are
// pending, req_tready is low, so a stalled receiver on rsp eventually holds off the byte
// stream. A synchronous reset empties the queue, drops any run in progress and restarts
// parsing at byte zero; RAM contents are not cleared.
module mgmt_frame_ssid_parser
   import mfsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] frame_byte
   input  logic                  req_tlast,   // end_of_frame
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // frame_ok, secured, bssid, ssid_length, ssid_byte
   output logic                  rsp_tlast    // last_of_run
);

   logic              queue_full;
   logic              push;
   desc_type          push_desc;
   logic              pop;
   logic              head_valid;
   desc_type          head_desc;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              out_ok;
   logic              out_secured;
   logic [BSSID_W-1:0] out_bssid;
   logic [LEN_W-1:0]  out_len;
   logic [7:0]        out_byte;

   // Byte parser.
   mfsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_desc  (push_desc),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   // SSID byte store, two frames deep.
   mfsp_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Frame descriptor queue.
   mfsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   // Result emitter.
   mfsp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_desc   (head_desc),
      .pop         (pop),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_ok      (out_ok),
      .out_secured (out_secured),
      .out_bssid   (out_bssid),
      .out_len     (out_len),
      .out_byte    (out_byte),
      .out_last    (rsp_tlast)
   );

   // Pack the result fields, out_ok in the lowest bit and out_byte highest.
   assign rsp_tdata = {out_byte, out_len, out_bssid, out_secured, out_ok};

endmodule

### tb/mgmt_frame_ssid_parser_tb.sv
// Self-checking testbench for the management frame SSID parser.
`timescale 1ns / 1ps

module mgmt_frame_ssid_parser_tb;
   import mfsp_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int DRAIN_CYCLES    = 20;
   localparam int RANDOM_FRAMES   = 2;
   localparam int MAX_PRINTED     = 40;
   localparam int HDR_BYTES       = 36;

   // Bit offsets of the result fields inside rsp_tdata.
   localparam int OK_BIT   = 0;
   localparam int SEC_BIT  = 1;
   localparam int BSS_LSB  = 2;
   localparam int LEN_LSB  = BSS_LSB + BSSID_W;
   localparam int BYTE_LSB = LEN_LSB + LEN_W;

   // One expected result word.
   typedef struct packed {
      logic               ok;
      logic               secured;
      logic [BSSID_W-1:0] bssid;
      logic [LEN_W-1:0]   keep_len;
      logic [7:0]         ssid_byte;
      logic               end_of_run;
   } ssid_word_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // Shadow copy of the parser state.
   logic [POS_W-1:0]   shadow_pos;
   logic               shadow_failed;
   logic [BSSID_W-1:0] shadow_bssid;
   logic               shadow_privacy;
   phase_type          shadow_phase;
   logic [7:0]         shadow_tag;
   logic [7:0]         shadow_remaining;
   logic               shadow_ssid_seen;
   logic [LEN_W-1:0]   shadow_ssid_count;
   logic [7:0]         shadow_ssid_bytes [SSID_BYTES];

   ssid_word_type expected_words [$];
   ssid_word_type want_word;
   logic [7:0]    frame_buf [$];

   int   gap_pct = 0;
   int   stall_pct = 0;
   logic rsp_hold = 1'b0;
   event hold_off_start;
   int   error_count = 0;
   int   cycle_count = 0;
   int   frames_sent = 0;
   int   words_checked = 0;

   mgmt_frame_ssid_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words still expected",
                  cycle_count, expected_words.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Counts one mismatch and prints it while fewer than MAX_PRINTED have been printed.
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < MAX_PRINTED)
         $display("Mismatch at cycle %0d: %s got 0x%0h, expected 0x%0h",
                  cycle_count, what, got, want);
      error_count++;
   endtask

   // Returns the shadow parser to its start-of-frame state.
   task automatic clear_shadow();
      shadow_pos        = '0;
      shadow_failed     = 1'b0;
      shadow_bssid      = '0;
      shadow_privacy    = 1'b0;
      shadow_phase      = PH_TAG;
      shadow_tag        = '0;
      shadow_remaining  = '0;
      shadow_ssid_seen  = 1'b0;
      shadow_ssid_count = '0;
   endtask

   // Advances the shadow parser by one accepted byte and queues the run of
   // result words that a final byte produces.
   task automatic parse_frame_byte(input logic [7:0] b, input logic eof);
      logic [POS_W-1:0] p;
      ssid_word_type    w;
      p = shadow_pos;
      if (p == 0 && (b & TYPE_MASK) != 0)
         shadow_failed = 1'b1;
      if (p >= POS_BSSID && p < POS_BSSID + BSSID_BYTES)
         shadow_bssid = shadow_bssid | (BSSID_W'(b) << (8 * (p - POS_BSSID)));
      if (p == POS_CAP)
         shadow_privacy = (b & PRIVACY_MASK) != 0;

      // Element walk from the first element byte on.
      if (p >= POS_ELEM) begin
         case (shadow_phase)
            PH_TAG: begin
               shadow_tag   = b;
               shadow_phase = PH_LEN;
            end
            PH_LEN: begin
               shadow_remaining = b;
               if (shadow_tag == TAG_SSID) begin
                  shadow_ssid_seen  = 1'b1;
                  shadow_ssid_count = '0;
               end
               if (b == 0)
                  shadow_phase = (shadow_tag == TAG_SSID) ? PH_DONE : PH_TAG;
               else
                  shadow_phase = PH_BODY;
            end
            PH_BODY: begin
               if (shadow_tag == TAG_SSID && shadow_ssid_count < SSID_BYTES) begin
                  shadow_ssid_bytes[shadow_ssid_count[IDX_W-1:0]] = b;
                  shadow_ssid_count++;
               end
               shadow_remaining--;
               if (shadow_remaining == 0)
                  shadow_phase = (shadow_tag == TAG_SSID) ? PH_DONE : PH_TAG;
            end
            default: ;
         endcase
      end
      if (shadow_pos != POS_LAST)
         shadow_pos++;

      if (eof) begin
         w = '0;
         if (shadow_failed || p < POS_MIN_END || shadow_phase != PH_DONE ||
             !shadow_ssid_seen) begin
            w.end_of_run = 1'b1;
            expected_words.push_back(w);
         end else begin
            w.ok       = 1'b1;
            w.secured  = shadow_privacy;
            w.bssid    = shadow_bssid;
            w.keep_len = shadow_ssid_count;
            if (shadow_ssid_count == 0) begin
               w.end_of_run = 1'b1;
               expected_words.push_back(w);
            end else begin
               for (int k = 0; k < shadow_ssid_count; k++) begin
                  w.ssid_byte  = shadow_ssid_bytes[k];
                  w.end_of_run = (k + 1 == shadow_ssid_count);
                  expected_words.push_back(w);
               end
            end
         end
         clear_shadow();
      end
   endtask

   // Sends one byte; called and returns at a falling edge.
   task automatic send_byte(input logic [7:0] b, input logic eof);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eof;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      parse_frame_byte(b, eof);
      @(negedge clock);
   endtask

   // Sends the frame held in frame_buf and empties it.
   task automatic send_frame();
      for (int i = 0; i < frame_buf.size(); i++)
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
      frames_sent++;
      frame_buf.delete();
   endtask

   // Idles the input and waits until every expected word has arrived.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do
         @(negedge clock);
      while (expected_words.size() != 0);
   endtask

   // Appends the 36-byte fixed part: header, timestamp, interval, capability.
   task automatic add_header(input logic [7:0] fc, input logic priv,
                             input logic [BSSID_W-1:0] bss);
      logic [7:0] cap;
      frame_buf.push_back(fc);
      for (int i = 1; i < HDR_BYTES; i++) begin
         if (i >= POS_BSSID && i < POS_BSSID + BSSID_BYTES)
            frame_buf.push_back(bss[8 * (i - POS_BSSID) +: 8]);
         else if (i == POS_CAP) begin
            cap = 8'($urandom);
            cap[4] = priv;
            frame_buf.push_back(cap);
         end else
            frame_buf.push_back(8'($urandom));
      end
   endtask

   // Appends one tag/length element; a negative fill gives random body bytes.
   task automatic add_element(input logic [7:0] tag, input int len, input int fill);
      frame_buf.push_back(tag);
      frame_buf.push_back(8'(len));
      for (int i = 0; i < len; i++)
         frame_buf.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
   endtask

   task automatic cut_frame(input int n);
      while (frame_buf.size() > n)
         void'(frame_buf.pop_back());
   endtask

   function automatic logic [BSSID_W-1:0] random_bssid();
      return BSSID_W'({$urandom, $urandom});
   endfunction

   // Builds one random frame: mostly well formed, some broken.
   task automatic build_random_frame();
      int         kind;
      int         pick;
      int         len;
      logic [7:0] fc;
      kind = $urandom_range(99);
      fc = 8'($urandom) & ~TYPE_MASK;
      if (kind < 6)
         fc = fc | 8'($urandom_range(3, 1) << 2);
      add_header(fc, 1'($urandom), random_bssid());

      // A short frame is cut somewhere inside the fixed part.
      if (kind >= 6 && kind < 10) begin
         cut_frame($urandom_range(HDR_BYTES, 1));
         return;
      end

      // Other elements ahead of the SSID.
      repeat ($urandom_range(2, 0)) begin
         len = ($urandom_range(99) < 5) ? $urandom_range(255, 9) : $urandom_range(8, 0);
         add_element(8'($urandom_range(255, 1)), len, -1);
      end

      if (kind >= 10 && kind < 14) begin
         // No SSID: end between elements, on a tag byte or on a length byte.
         pick = $urandom_range(2);
         if (pick >= 1)
            frame_buf.push_back(8'($urandom_range(255, 1)));
         if (pick == 2)
            frame_buf.push_back(8'($urandom));
         if (frame_buf.size() == HDR_BYTES)
            add_element(8'($urandom_range(255, 1)), $urandom_range(4, 0), -1);
         return;
      end

      pick = $urandom_range(99);
      if (pick < 70)
         len = $urandom_range(10, 0);
      else if (pick < 85)
         len = $urandom_range(32, 11);
      else if (pick < 97)
         len = $urandom_range(48, 33);
      else
         len = $urandom_range(255, 49);
      add_element(TAG_SSID, len, -1);

      // Trailing bytes after the SSID are ignored.
      repeat ($urandom_range(4, 0))
         frame_buf.push_back(8'($urandom));

      // A truncated frame ends somewhere in the element area.
      if (kind >= 14 && kind < 20 && frame_buf.size() > HDR_BYTES + 1)
         cut_frame($urandom_range(frame_buf.size() - 1, HDR_BYTES + 1));
   endtask

   // Receiver side: random stalls, or a long hold-off when one is running.
   always @(negedge clock)
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= stall_pct);

   // Long hold-off of the result channel, counted on rising edges.
   always begin
      @(hold_off_start);
      rsp_hold = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // Compares each accepted result word with the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0)
            report_mismatch("unexpected word", 64'(rsp_tdata), '0);
         else begin
            want_word = expected_words.pop_front();
            if (rsp_tdata[OK_BIT] !== want_word.ok)
               report_mismatch("frame_ok", 64'(rsp_tdata[OK_BIT]), 64'(want_word.ok));
            if (rsp_tdata[SEC_BIT] !== want_word.secured)
               report_mismatch("secured", 64'(rsp_tdata[SEC_BIT]), 64'(want_word.secured));
            if (rsp_tdata[BSS_LSB +: BSSID_W] !== want_word.bssid)
               report_mismatch("bssid", 64'(rsp_tdata[BSS_LSB +: BSSID_W]),
                               64'(want_word.bssid));
            if (rsp_tdata[LEN_LSB +: LEN_W] !== want_word.keep_len)
               report_mismatch("ssid_length", 64'(rsp_tdata[LEN_LSB +: LEN_W]),
                               64'(want_word.keep_len));
            if (rsp_tdata[BYTE_LSB +: 8] !== want_word.ssid_byte)
               report_mismatch("ssid_byte", 64'(rsp_tdata[BYTE_LSB +: 8]),
                               64'(want_word.ssid_byte));
            if (rsp_tlast !== want_word.end_of_run)
               report_mismatch("last_of_run", 64'(rsp_tlast), 64'(want_word.end_of_run));
         end
         words_checked++;
      end
   end

   // Frames that parse: short SSID after another element, empty and clipped SSIDs.
   task automatic test_good_frames();
      add_header(8'h00, 1'b1, {BSSID_W{1'b1}});
      add_element(8'h01, 1, -1);
      add_element(TAG_SSID, 2, 8'hFF);
      send_frame();

      // Empty SSID, with a second SSID and junk after it that must be ignored.
      add_header(8'hF3, 1'b0, '0);
      add_element(TAG_SSID, 0, -1);
      add_element(TAG_SSID, 0, -1);
      frame_buf.push_back(8'hA5);
      send_frame();

      // One byte more than can be kept.
      add_header(8'h50, 1'b0, random_bssid());
      add_element(TAG_SSID, SSID_BYTES + 1, -1);
      send_frame();
      wait_drained();
   endtask

   // Frames that fail for each of the failure reasons.
   task automatic test_bad_frames();
      // Short frames: one byte and 35 bytes.
      frame_buf.push_back(8'h00);
      send_frame();
      add_header(8'h80, 1'b1, random_bssid());
      cut_frame(HDR_BYTES - 1);
      send_frame();

      // A nonzero type in byte zero on an otherwise good frame.
      add_header(8'h08, 1'b1, random_bssid());
      add_element(TAG_SSID, 0, -1);
      send_frame();

      // Truncated inside the SSID body.
      add_header(8'h80, 1'b1, random_bssid());
      add_element(TAG_SSID, 4, -1);
      cut_frame(frame_buf.size() - 2);
      send_frame();

      // No SSID: the frame ends on a tag byte.
      add_header(8'h80, 1'b1, random_bssid());
      frame_buf.push_back(8'h30);
      send_frame();
      wait_drained();
   endtask

   // Result channel held off while frames keep coming, so the input stalls.
   task automatic test_back_pressure();
      -> hold_off_start;
      repeat (2) begin
         add_header(8'h80, 1'($urandom), random_bssid());
         add_element(TAG_SSID, 2, -1);
         send_frame();
      end
      frame_buf.push_back(8'h00);
      send_frame();
      wait_drained();
   endtask

   // Random frames under one idling pattern, with a full drain halfway.
   task automatic test_random_traffic(input int sender_gap, input int receiver_stall);
      gap_pct   = sender_gap;
      stall_pct = receiver_stall;
      for (int i = 0; i < RANDOM_FRAMES; i++) begin
         build_random_frame();
         send_frame();
         if (i == RANDOM_FRAMES / 2)
            wait_drained();
      end
      wait_drained();
      gap_pct   = 0;
      stall_pct = 0;
   endtask

   initial begin
      clear_shadow();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // No idling.
      test_good_frames();

      // Sender idle about half of the time.
      gap_pct = 51;
      test_bad_frames();
      gap_pct = 0;

      // Receiver stalling about half of the time, plus a long hold-off.
      stall_pct = 51;
      test_back_pressure();
      stall_pct = 0;

      // Both sides idling.
      test_random_traffic(31, 31);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_words.size() != 0)
         report_mismatch("words never delivered", 64'(expected_words.size()), '0);

      $display("Sent %0d frames and checked %0d result words in %0d cycles.",
               frames_sent, words_checked, cycle_count);
      $display("Covered good, empty-SSID, clipped, short, non-management, truncated "
               , "and SSID-less frames under back-pressure and idling.");
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
